/* rtl/jliq_pkg.sv */
// shared constants, types and helper functions of the json large integer quoter
package jliq_pkg;

    // token buffer geometry
    localparam int TOKEN_BUFFER_DEPTH = 32;
    localparam int TOK_ADDR_W         = $clog2(TOKEN_BUFFER_DEPTH);
    localparam int TOK_CNT_W          = $clog2(TOKEN_BUFFER_DEPTH + 1);

    // datapath widths
    localparam int LIMIT_W    = 63;
    localparam int MAG_W      = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;

    // character codes
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_PLUS      = 8'h2B;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_LOW_E     = 8'h65;
    localparam logic [7:0] CHAR_UP_E      = 8'h45;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;

    // register map: index bit of the byte address
    localparam logic REG_POS_LIMIT = 1'b0;
    localparam logic REG_NEG_LIMIT = 1'b1;

    localparam logic [LIMIT_W-1:0] POS_LIMIT_RST = 63'd2147483647;
    localparam logic [LIMIT_W-1:0] NEG_LIMIT_RST = 63'd2147483648;

    // write port of the token buffer
    typedef struct packed {
        logic                  en;
        logic [TOK_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } tok_wr_t;

    // pieces of output that one input beat causes, in emission order
    typedef struct packed {
        logic flush_pre;
        logic minus;
        logic plain;
        logic flush_post;
        logic end_minus;
    } plan_t;

    // sequencer states
    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECIDE = 9'b000000010,
        ST_QOPEN  = 9'b000000100,
        ST_NEG    = 9'b000001000,
        ST_BYTES  = 9'b000010000,
        ST_QCLOSE = 9'b000100000,
        ST_MINUS  = 9'b001000000,
        ST_PLAIN  = 9'b010000000,
        ST_EMINUS = 9'b100000000
    } state_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_mark(input logic [7:0] c);
        return (c == CHAR_DOT) || (c == CHAR_LOW_E) || (c == CHAR_UP_E) ||
               (c == CHAR_PLUS) || (c == CHAR_MINUS);
    endfunction

    // mag * 10 + digit, saturating at all ones
    function automatic logic [MAG_W-1:0] mag_step(input logic [MAG_W-1:0] mag,
                                                  input logic [7:0] c);
        logic [MAG_W+3:0] wide;
        logic [MAG_W-1:0] res;
        wide = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {{MAG_W{1'b0}}, c[3:0]};
        if (wide[MAG_W+3:MAG_W] != 4'd0)
        begin
            res = '1;
        end
        else
        begin
            res = wide[MAG_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/jliq_token_ram.sv */
// token byte buffer: one write port, one registered read port
module jliq_token_ram
    import jliq_pkg::*;
(
    input  logic                  clk,
    input  tok_wr_t               wr,
    input  logic [TOK_ADDR_W-1:0] rd_addr,
    output logic [7:0]            rd_data
);

    logic [7:0] token_mem [TOKEN_BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            token_mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= token_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/json_large_integer_quoter.sv */
// json large integer quoter: copies a json byte stream, quoting out-of-range integers
//
// input channel s_*: one text byte per beat, s_tlast marks the last byte of a document.
// output channel m_*: one rewritten byte per beat; m_tlast marks the last byte caused
// by an input beat, m_tuser[0] the last byte of the document, m_tuser[1] bytes of a
// released token that overflowed the token buffer.
// apb port: positive limit at byte address 0, negative limit magnitude at address 8.
// a byte that passes straight through is registered on its accept edge and shows on
// m_* the next cycle; such bytes flow at one per cycle while m_tready stays high.
// bytes of a number token are held in the token buffer ram until the token ends; the
// ending beat is accepted, then the range compare runs, then the bytes (quotes and
// sign included) are emitted one after another, read through the single read port of
// that ram. any other beat that emits several bytes is accepted and then emits them
// one after another. a beat that emits nothing leaves the sequencer idle. s_tready is
// high only while the sequencer is idle; a stalled m_tready holds the output register
// and the sequencer.
// reset clears all parse state and loads the default limits; the ram needs no clearing.
module json_large_integer_quoter
    import jliq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,
    output logic [1:0]            m_tuser,   // [0] doc_end, [1] token_truncated
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t                 state_reg, state_next;
    plan_t                  plan_reg, plan_next;
    logic                   in_string_reg, in_string_next;
    logic                   escape_reg, escape_next;
    logic                   minus_pend_reg, minus_pend_next;
    logic                   in_token_reg, in_token_next;
    logic                   float_reg, float_next;
    logic                   neg_reg, neg_next;
    logic [MAG_W-1:0]       mag_reg, mag_next;
    logic [TOK_CNT_W-1:0]   count_reg, count_next;
    logic                   overrun_reg, overrun_next;
    logic                   quote_reg, quote_next;
    logic [TOK_ADDR_W-1:0]  idx_reg, idx_next;
    logic [7:0]             plain_byte_reg, plain_byte_next;
    logic                   last_reg, last_next;
    logic [LIMIT_W-1:0]     pos_limit_reg, pos_limit_next;
    logic [LIMIT_W-1:0]     neg_limit_reg, neg_limit_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [7:0]             m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;

    logic                   accept;
    logic                   out_free;
    logic                   cfg_write;
    logic                   c_digit;
    logic                   c_mark;
    tok_wr_t                tok_wr;
    logic [7:0]             tok_rd_data;

    // accept-time decode results
    plan_t                  plan_in;
    logic                   do_plain;
    logic                   start_tok;
    logic                   start_neg;
    logic                   store_byte;
    logic                   add_digit;
    logic                   set_float;
    logic                   in_string_acc;
    logic                   escape_acc;
    logic                   minus_acc;
    logic                   in_token_acc;

    // sequencer helpers
    logic                   emit_fire;
    logic [7:0]             emit_byte;
    logic                   emit_trunc;
    logic                   emit_run_end;
    logic                   emit_doc;
    logic                   step_done;
    plan_t                  step_clr;
    plan_t                  plan_rest;
    logic                   flush_done;
    logic                   quote_now;
    logic [LIMIT_W-1:0]     sel_limit;
    logic [TOK_CNT_W-1:0]   wr_off;
    logic [TOK_CNT_W-1:0]   nb;
    logic [TOK_CNT_W-1:0]   nb_m1;
    logic                   single_simple;

    // first piece of a plan still to be emitted
    function automatic state_t next_of(input plan_t p, input logic q, input logic n);
        state_t f;
        state_t r;
        f = q ? ST_QOPEN : (n ? ST_NEG : ST_BYTES);
        priority if (p.flush_pre)
        begin
            r = f;
        end
        else if (p.minus)
        begin
            r = ST_MINUS;
        end
        else if (p.plain)
        begin
            r = ST_PLAIN;
        end
        else if (p.flush_post)
        begin
            r = f;
        end
        else if (p.end_minus)
        begin
            r = ST_EMINUS;
        end
        else
        begin
            r = ST_IDLE;
        end
        return r;
    endfunction

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign c_digit   = is_digit(s_tdata);
    assign c_mark    = is_mark(s_tdata);

    // register readback
    assign prdata = (paddr[3] == REG_NEG_LIMIT) ? {1'b0, neg_limit_reg}
                                                : {1'b0, pos_limit_reg};

    // token buffer
    jliq_token_ram u_token_ram (
        .clk     (clk),
        .wr      (tok_wr),
        .rd_addr (idx_next),
        .rd_data (tok_rd_data)
    );

    // decode of the incoming beat against the parse state
    always_comb
    begin
        plan_in       = '0;
        do_plain      = 1'b0;
        start_tok     = 1'b0;
        start_neg     = 1'b0;
        store_byte    = 1'b0;
        add_digit     = 1'b0;
        set_float     = 1'b0;
        in_string_acc = in_string_reg;
        escape_acc    = escape_reg;
        minus_acc     = minus_pend_reg;
        in_token_acc  = in_token_reg;

        priority if (in_token_reg)
        begin
            if (c_digit)
            begin
                store_byte = 1'b1;
                add_digit  = 1'b1;
            end
            else if (c_mark)
            begin
                store_byte = 1'b1;
                set_float  = 1'b1;
            end
            else
            begin
                plan_in.flush_pre = 1'b1;
                in_token_acc      = 1'b0;
                do_plain          = 1'b1;
            end
        end
        else if (minus_pend_reg)
        begin
            minus_acc = 1'b0;
            if (c_digit)
            begin
                start_tok = 1'b1;
                start_neg = 1'b1;
            end
            else
            begin
                plan_in.minus = 1'b1;
                do_plain      = 1'b1;
            end
        end
        else
        begin
            do_plain = 1'b1;
        end

        // ordinary byte handling
        if (do_plain)
        begin
            priority if (in_string_reg)
            begin
                plan_in.plain = 1'b1;
                priority if (escape_reg)
                begin
                    escape_acc = 1'b0;
                end
                else if (s_tdata == CHAR_BACKSLASH)
                begin
                    escape_acc = 1'b1;
                end
                else if (s_tdata == CHAR_QUOTE)
                begin
                    in_string_acc = 1'b0;
                end
                else
                begin
                    in_string_acc = in_string_reg;
                end
            end
            else if (s_tdata == CHAR_QUOTE)
            begin
                in_string_acc = 1'b1;
                plan_in.plain = 1'b1;
            end
            else if (c_digit)
            begin
                start_tok = 1'b1;
            end
            else if (s_tdata == CHAR_MINUS)
            begin
                minus_acc = 1'b1;
            end
            else
            begin
                plan_in.plain = 1'b1;
            end
        end

        if (start_tok)
        begin
            in_token_acc = 1'b1;
        end

        // end of document releases what is pending and clears the parse state
        if (s_tlast)
        begin
            plan_in.flush_post = in_token_acc;
            plan_in.end_minus  = minus_acc;
            in_string_acc      = 1'b0;
            escape_acc         = 1'b0;
            minus_acc          = 1'b0;
            in_token_acc       = 1'b0;
        end
    end

    // buffer indexes and range compare
    assign wr_off        = count_reg - {{(TOK_CNT_W-1){1'b0}}, neg_reg};
    assign nb            = wr_off;
    assign nb_m1         = nb - {{(TOK_CNT_W-1){1'b0}}, 1'b1};
    assign sel_limit     = neg_reg ? neg_limit_reg : pos_limit_reg;
    assign quote_now     = !float_reg && (mag_reg > {1'b0, sel_limit});
    assign single_simple = !plan_in.flush_pre && !plan_in.flush_post &&
                           ($countones({plan_in.minus, plan_in.plain, plan_in.end_minus}) == 1);

    // sequencer and state update
    always_comb
    begin
        state_next      = state_reg;
        plan_next       = plan_reg;
        in_string_next  = in_string_reg;
        escape_next     = escape_reg;
        minus_pend_next = minus_pend_reg;
        in_token_next   = in_token_reg;
        float_next      = float_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        count_next      = count_reg;
        overrun_next    = overrun_reg;
        quote_next      = quote_reg;
        idx_next        = idx_reg;
        plain_byte_next = plain_byte_reg;
        last_next       = last_reg;
        tok_wr          = '0;
        emit_fire       = 1'b0;
        emit_byte       = CHAR_MINUS;
        emit_trunc      = 1'b0;
        emit_run_end    = 1'b0;
        emit_doc        = last_reg;
        step_done       = 1'b0;
        step_clr        = '0;
        plan_rest       = plan_reg;
        flush_done      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_string_next  = in_string_acc;
                    escape_next     = escape_acc;
                    minus_pend_next = minus_acc;
                    in_token_next   = in_token_acc;
                    plain_byte_next = s_tdata;
                    last_next       = s_tlast;

                    // token buffer and magnitude
                    if (start_tok)
                    begin
                        float_next   = 1'b0;
                        neg_next     = start_neg;
                        mag_next     = {{(MAG_W-4){1'b0}}, s_tdata[3:0]};
                        count_next   = start_neg ? TOK_CNT_W'(2) : TOK_CNT_W'(1);
                        overrun_next = 1'b0;
                        tok_wr.en    = 1'b1;
                        tok_wr.addr  = '0;
                        tok_wr.data  = s_tdata;
                    end
                    else if (store_byte)
                    begin
                        if (set_float)
                        begin
                            float_next = 1'b1;
                        end
                        if (add_digit)
                        begin
                            mag_next = mag_step(mag_reg, s_tdata);
                        end
                        if (count_reg < TOK_CNT_W'(TOKEN_BUFFER_DEPTH))
                        begin
                            tok_wr.en   = 1'b1;
                            tok_wr.addr = wr_off[TOK_ADDR_W-1:0];
                            tok_wr.data = s_tdata;
                            count_next  = count_reg + {{(TOK_CNT_W-1){1'b0}}, 1'b1};
                        end
                        else
                        begin
                            overrun_next = 1'b1;
                        end
                    end

                    // schedule the output of this beat
                    if (plan_in.flush_pre || plan_in.flush_post)
                    begin
                        plan_next  = plan_in;
                        state_next = ST_DECIDE;
                    end
                    else if (single_simple && out_free)
                    begin
                        emit_fire    = 1'b1;
                        emit_byte    = plan_in.plain ? s_tdata : CHAR_MINUS;
                        emit_run_end = 1'b1;
                        emit_doc     = s_tlast;
                        plan_next    = '0;
                    end
                    else
                    begin
                        plan_next  = plan_in;
                        state_next = next_of(plan_in, quote_reg, neg_reg);
                    end
                end
            end

            ST_DECIDE:
            begin
                quote_next = quote_now;
                idx_next   = '0;
                state_next = next_of(plan_reg, quote_now, neg_reg);
            end

            ST_QOPEN:
            begin
                if (out_free)
                begin
                    emit_fire  = 1'b1;
                    emit_byte  = CHAR_QUOTE;
                    emit_trunc = overrun_reg;
                    state_next = neg_reg ? ST_NEG : ST_BYTES;
                end
            end

            ST_NEG:
            begin
                if (out_free)
                begin
                    emit_fire  = 1'b1;
                    emit_byte  = CHAR_MINUS;
                    emit_trunc = overrun_reg;
                    state_next = ST_BYTES;
                end
            end

            ST_BYTES:
            begin
                if (out_free)
                begin
                    emit_fire  = 1'b1;
                    emit_byte  = tok_rd_data;
                    emit_trunc = overrun_reg;
                    if (idx_reg == nb_m1[TOK_ADDR_W-1:0])
                    begin
                        if (quote_reg)
                        begin
                            state_next = ST_QCLOSE;
                        end
                        else
                        begin
                            flush_done = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + {{(TOK_ADDR_W-1){1'b0}}, 1'b1};
                    end
                end
            end

            ST_QCLOSE:
            begin
                if (out_free)
                begin
                    emit_fire  = 1'b1;
                    emit_byte  = CHAR_QUOTE;
                    emit_trunc = overrun_reg;
                    flush_done = 1'b1;
                end
            end

            ST_MINUS:
            begin
                if (out_free)
                begin
                    emit_fire      = 1'b1;
                    emit_byte      = CHAR_MINUS;
                    step_done      = 1'b1;
                    step_clr.minus = 1'b1;
                end
            end

            ST_PLAIN:
            begin
                if (out_free)
                begin
                    emit_fire      = 1'b1;
                    emit_byte      = plain_byte_reg;
                    step_done      = 1'b1;
                    step_clr.plain = 1'b1;
                end
            end

            ST_EMINUS:
            begin
                if (out_free)
                begin
                    emit_fire          = 1'b1;
                    emit_byte          = CHAR_MINUS;
                    step_done          = 1'b1;
                    step_clr.end_minus = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a released token leaves the buffer empty
        if (flush_done)
        begin
            step_done           = 1'b1;
            step_clr.flush_pre  = 1'b1;
            step_clr.flush_post = 1'b1;
            float_next          = 1'b0;
            neg_next            = 1'b0;
            mag_next            = '0;
            count_next          = '0;
            overrun_next        = 1'b0;
            idx_next            = '0;
        end

        // move on to the next piece of the plan
        if (step_done)
        begin
            plan_rest    = plan_reg & ~step_clr;
            plan_next    = plan_rest;
            state_next   = next_of(plan_rest, quote_reg, neg_reg);
            emit_run_end = (plan_rest == '0);
        end
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (emit_fire)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = emit_byte;
            m_tlast_next  = emit_run_end;
            m_tuser_next  = {emit_trunc, emit_run_end && emit_doc};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // limit registers
    always_comb
    begin
        pos_limit_next = pos_limit_reg;
        neg_limit_next = neg_limit_reg;
        if (cfg_write)
        begin
            if (paddr[3] == REG_NEG_LIMIT)
            begin
                neg_limit_next = pwdata[LIMIT_W-1:0];
            end
            else
            begin
                pos_limit_next = pwdata[LIMIT_W-1:0];
            end
        end
    end

    // control and token state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            plan_reg       <= '0;
            in_string_reg  <= 1'b0;
            escape_reg     <= 1'b0;
            minus_pend_reg <= 1'b0;
            in_token_reg   <= 1'b0;
            float_reg      <= 1'b0;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
            count_reg      <= '0;
            overrun_reg    <= 1'b0;
            quote_reg      <= 1'b0;
            idx_reg        <= '0;
            last_reg       <= 1'b0;
            pos_limit_reg  <= POS_LIMIT_RST;
            neg_limit_reg  <= NEG_LIMIT_RST;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            plan_reg       <= plan_next;
            in_string_reg  <= in_string_next;
            escape_reg     <= escape_next;
            minus_pend_reg <= minus_pend_next;
            in_token_reg   <= in_token_next;
            float_reg      <= float_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            count_reg      <= count_next;
            overrun_reg    <= overrun_next;
            quote_reg      <= quote_next;
            idx_reg        <= idx_next;
            last_reg       <= last_next;
            pos_limit_reg  <= pos_limit_next;
            neg_limit_reg  <= neg_limit_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        plain_byte_reg <= plain_byte_next;
        m_tdata_reg    <= m_tdata_next;
        m_tlast_reg    <= m_tlast_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
